// ===== rtl/apm_pkg.sv =====
package apm_pkg;

  // Scaling applied to coordinate differences before the rotations.
  localparam int GUARD_BITS = 26;

  // Vectors carried side by side through the rotation chain.
  localparam int NUM_VEC   = 3;
  localparam int VEC_START = 0;
  localparam int VEC_END   = 1;
  localparam int VEC_POINT = 2;

  // Configuration register indexes.
  localparam int            REG_INDEX_W      = 3;
  localparam logic [2:0]    REG_CENTER_X     = 3'd0;
  localparam logic [2:0]    REG_CENTER_Y     = 3'd1;
  localparam logic [2:0]    REG_START_X      = 3'd2;
  localparam logic [2:0]    REG_START_Y      = 3'd3;
  localparam logic [2:0]    REG_END_X        = 3'd4;
  localparam logic [2:0]    REG_END_Y        = 3'd5;
  localparam logic [2:0]    REG_CLOCKWISE    = 3'd6;

  // Per-request control that travels alongside the angle data.
  typedef struct packed {
    logic full_circle;
    logic clockwise;
  } flags_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn32(input int idx);
    logic [31:0] t;
    case (idx & 31)
      0:  t = 32'h20000000;
      1:  t = 32'h12E4051E;
      2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;
      5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;
      7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F;
      10: t = 32'h000A2F98;
      11: t = 32'h000517CC;
      12: t = 32'h00028BE6;
      13: t = 32'h000145F3;
      14: t = 32'h0000A2FA;
      15: t = 32'h0000517D;
      16: t = 32'h000028BE;
      17: t = 32'h0000145F;
      18: t = 32'h00000A30;
      19: t = 32'h00000518;
      20: t = 32'h0000028C;
      21: t = 32'h00000146;
      22: t = 32'h000000A3;
      23: t = 32'h00000051;
      24: t = 32'h00000029;
      25: t = 32'h00000014;
      26: t = 32'h0000000A;
      27: t = 32'h00000005;
      28: t = 32'h00000003;
      29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

  // Table angle rounded half up to the given angle width.
  function automatic logic [31:0] table_angle(input int idx, input int bits);
    logic [32:0] t;
    logic [32:0] r;
    t = {1'b0, atan_turn32(idx)};
    if (bits >= 32) begin
      r = t;
    end else begin
      r = (t + (33'd1 << (32 - bits - 1))) >> (32 - bits);
    end
    return r[31:0];
  endfunction

endpackage

// ===== rtl/apm_cell.sv =====
module apm_cell #(
  parameter int XW         = 45,
  parameter int ANGLE_BITS = 16,
  parameter int STAGE      = 0
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  input  apm_pkg::flags_t                              in_flags,
  input  logic [apm_pkg::NUM_VEC-1:0][XW-1:0]          x_in,
  input  logic [apm_pkg::NUM_VEC-1:0][XW-1:0]          y_in,
  input  logic [apm_pkg::NUM_VEC-1:0][ANGLE_BITS-1:0]  z_in,
  input  logic [apm_pkg::NUM_VEC-1:0]                  zero_in,
  output logic                                         out_valid,
  output apm_pkg::flags_t                              out_flags,
  output logic [apm_pkg::NUM_VEC-1:0][XW-1:0]          x_out,
  output logic [apm_pkg::NUM_VEC-1:0][XW-1:0]          y_out,
  output logic [apm_pkg::NUM_VEC-1:0][ANGLE_BITS-1:0]  z_out,
  output logic [apm_pkg::NUM_VEC-1:0]                  zero_out
);
  import apm_pkg::*;

  localparam logic [31:0] ANG32 = table_angle(STAGE, ANGLE_BITS);
  localparam logic [ANGLE_BITS-1:0] ANG = ANG32[ANGLE_BITS-1:0];

  logic [NUM_VEC-1:0][XW-1:0]         x_next;
  logic [NUM_VEC-1:0][XW-1:0]         y_next;
  logic [NUM_VEC-1:0][ANGLE_BITS-1:0] z_next;

  // One micro-rotation per vector: rotate toward the x axis.
  for (genvar v = 0; v < NUM_VEC; v++) begin : g_vec
    logic [XW-1:0] xs;
    logic [XW-1:0] ys;
    assign xs = $signed(x_in[v]) >>> STAGE;
    assign ys = $signed(y_in[v]) >>> STAGE;
    always_comb begin
      if (!y_in[v][XW-1]) begin
        x_next[v] = x_in[v] + ys;
        y_next[v] = y_in[v] - xs;
        z_next[v] = z_in[v] + ANG;
      end else begin
        x_next[v] = x_in[v] - ys;
        y_next[v] = y_in[v] + xs;
        z_next[v] = z_in[v] - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_flags <= in_flags;
    x_out     <= x_next;
    y_out     <= y_next;
    z_out     <= z_next;
    zero_out  <= zero_in;
  end

endmodule

// ===== rtl/apm_decide.sv =====
module apm_decide #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  input  apm_pkg::flags_t                              in_flags,
  input  logic [apm_pkg::NUM_VEC-1:0][ANGLE_BITS-1:0]  z_in,
  input  logic [apm_pkg::NUM_VEC-1:0]                  zero_in,
  output logic                                         done,
  output logic                                         on_arc
);
  import apm_pkg::*;

  localparam logic [ANGLE_BITS:0] TURN = {1'b1, {ANGLE_BITS{1'b0}}};

  logic [ANGLE_BITS:0] t1;
  logic [ANGLE_BITS:0] t2;
  logic [ANGLE_BITS:0] tx;
  logic [ANGLE_BITS:0] t2_wrap;
  logic [ANGLE_BITS:0] tx_wrap;
  logic                hit;

  // A vector at the center has angle zero.
  assign t1 = zero_in[VEC_START] ? '0 : {1'b0, z_in[VEC_START]};
  assign t2 = zero_in[VEC_END]   ? '0 : {1'b0, z_in[VEC_END]};
  assign tx = zero_in[VEC_POINT] ? '0 : {1'b0, z_in[VEC_POINT]};

  always_comb begin
    if (in_flags.clockwise) begin
      tx_wrap = (tx <= t1) ? tx + TURN : tx;
      t2_wrap = (t2 < t1)  ? t2 + TURN : t2;
      hit     = (tx_wrap >= t2_wrap);
    end else begin
      t2_wrap = (t2 <= t1) ? t2 + TURN : t2;
      tx_wrap = (tx < t1)  ? tx + TURN : tx;
      hit     = (tx_wrap <= t2_wrap);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    on_arc <= in_flags.full_circle | hit;
  end

  a_done_follows_valid: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> done)
    else $error("result strobe missing after a valid request");

  a_full_circle_hits: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_flags.full_circle |=> on_arc)
    else $error("full circle request did not report on_arc");

endmodule

// ===== rtl/arc_point_membership_top.sv =====
// An accepted request passes the entry register, each rotation cell and the done register.
// Throughput: one request per cycle; the rotation chain is fully unrolled.
// The receiver cannot stall: on_arc is valid for exactly the done cycle.
// Reset (rst, synchronous) clears all in-flight requests and sets every
// configuration register to zero; busy is high only while rst is high.
module arc_point_membership_top #(
  parameter int COORD_WIDTH   = 16,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       point_x,
  input  logic signed [COORD_WIDTH-1:0]       point_y,
  output logic                                done,
  output logic                                on_arc,
  input  logic                                wr_en,
  input  logic [apm_pkg::REG_INDEX_W-1:0]     wr_index,
  input  logic [COORD_WIDTH-1:0]              wr_data
);
  import apm_pkg::*;

  // Datapath width of the rotation vectors. Differences need one bit over
  // the coordinates, the guard bits add resolution, and two more bits cover
  // the CORDIC gain and the diagonal length.
  localparam int DW = COORD_WIDTH + 1;
  localparam int XW = DW + GUARD_BITS + 2;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS - 1){1'b0}}};

  // Configuration registers. The user changes them only while the block is idle; the block does not enforce it.
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic                          clockwise_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      start_x        <= '0;
      start_y        <= '0;
      end_x          <= '0;
      end_y          <= '0;
      clockwise_mode <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_CENTER_X:  center_x       <= wr_data;
        REG_CENTER_Y:  center_y       <= wr_data;
        REG_START_X:   start_x        <= wr_data;
        REG_START_Y:   start_y        <= wr_data;
        REG_END_X:     end_x          <= wr_data;
        REG_END_Y:     end_y          <= wr_data;
        REG_CLOCKWISE: clockwise_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  // A request is taken whenever start is high outside reset. The arc limits
  // run through the same chain as the query point, so every request carries
  // its own start, end and query angles and no precomputed state is needed.
  logic accept;
  assign busy   = rst;
  assign accept = start & ~busy;

  // Pipeline buses: index 0 is the entry register, index i+1 the output of
  // rotation cell i.
  logic                                         sv [CORDIC_STAGES+1];
  flags_t                                       sf [CORDIC_STAGES+1];
  logic [NUM_VEC-1:0][XW-1:0]                   sx [CORDIC_STAGES+1];
  logic [NUM_VEC-1:0][XW-1:0]                   sy [CORDIC_STAGES+1];
  logic [NUM_VEC-1:0][ANGLE_BITS-1:0]           sz [CORDIC_STAGES+1];
  logic [NUM_VEC-1:0]                           szero [CORDIC_STAGES+1];

  // Entry stage: form the differences to the center, scale them by the
  // guard bits and fold the left half plane onto the right half, starting
  // the angle at half a turn for folded vectors.
  logic [NUM_VEC-1:0][COORD_WIDTH-1:0] ax;
  logic [NUM_VEC-1:0][COORD_WIDTH-1:0] ay;
  logic [NUM_VEC-1:0][XW-1:0]          x0_next;
  logic [NUM_VEC-1:0][XW-1:0]          y0_next;
  logic [NUM_VEC-1:0][ANGLE_BITS-1:0]  z0_next;
  logic [NUM_VEC-1:0]                  zero0_next;
  flags_t                              flags0_next;

  assign ax[VEC_START] = start_x;
  assign ay[VEC_START] = start_y;
  assign ax[VEC_END]   = end_x;
  assign ay[VEC_END]   = end_y;
  assign ax[VEC_POINT] = point_x;
  assign ay[VEC_POINT] = point_y;

  for (genvar v = 0; v < NUM_VEC; v++) begin : g_entry
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [XW-1:0]        xs;
    logic [XW-1:0]        ys;
    assign dx = $signed({ax[v][COORD_WIDTH-1], ax[v]}) -
                $signed({center_x[COORD_WIDTH-1], center_x});
    assign dy = $signed({ay[v][COORD_WIDTH-1], ay[v]}) -
                $signed({center_y[COORD_WIDTH-1], center_y});
    assign xs = {{2{dx[DW-1]}}, dx, {GUARD_BITS{1'b0}}};
    assign ys = {{2{dy[DW-1]}}, dy, {GUARD_BITS{1'b0}}};
    always_comb begin
      if (dx[DW-1]) begin
        x0_next[v] = -xs;
        y0_next[v] = -ys;
        z0_next[v] = HALF_TURN;
      end else begin
        x0_next[v] = xs;
        y0_next[v] = ys;
        z0_next[v] = '0;
      end
    end
    assign zero0_next[v] = (dx == '0) && (dy == '0);
  end

  assign flags0_next.full_circle = (start_x == end_x) && (start_y == end_y);
  assign flags0_next.clockwise   = clockwise_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    sf[0]    <= flags0_next;
    sx[0]    <= x0_next;
    sy[0]    <= y0_next;
    sz[0]    <= z0_next;
    szero[0] <= zero0_next;
  end

  // The row of rotation cells. Each cell applies one micro-rotation to all
  // three vectors and hands them to its neighbor on the next clock.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_chain
    apm_cell #(
      .XW         (XW),
      .ANGLE_BITS (ANGLE_BITS),
      .STAGE      (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sv[i]),
      .in_flags  (sf[i]),
      .x_in      (sx[i]),
      .y_in      (sy[i]),
      .z_in      (sz[i]),
      .zero_in   (szero[i]),
      .out_valid (sv[i+1]),
      .out_flags (sf[i+1]),
      .x_out     (sx[i+1]),
      .y_out     (sy[i+1]),
      .z_out     (sz[i+1]),
      .zero_out  (szero[i+1])
    );
  end

  // Wrap-and-compare of the three final angles; registered result strobe.
  apm_decide #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_decide (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sv[CORDIC_STAGES]),
    .in_flags (sf[CORDIC_STAGES]),
    .z_in     (sz[CORDIC_STAGES]),
    .zero_in  (szero[CORDIC_STAGES]),
    .done     (done),
    .on_arc   (on_arc)
  );

  localparam int LATENCY = CORDIC_STAGES + 2;

  // Every accepted request produces its strobe after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted request produced no result strobe");

  // No strobe without a request the fixed latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching request");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import apm_pkg::*;

  // Block geometry as instantiated below.
  localparam int COORD_W = 16;
  localparam int ANGLE_W = 16;
  localparam int STAGES  = 16;
  localparam int LATENCY = STAGES + 2;

  // One full turn in binary angle units.
  localparam longint TURN = longint'(1) << ANGLE_W;

  // An index past the last register. Writes to it must leave the arc untouched.
  localparam logic [REG_INDEX_W-1:0] REG_SPARE = 3'd7;

  // atan(2^-i) in units of 2^-32 turn, one entry per rotation stage.
  localparam logic [31:0] ATAN_TURN [0:STAGES-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef logic signed [COORD_W-1:0] coord_t;

  // The request stream mixes point queries with register writes and with
  // pauses that hold the sender until every pending verdict has come back.
  typedef enum logic [1:0] {STEP_POINT, STEP_WRITE, STEP_WAIT} step_kind_t;

  typedef struct {
    step_kind_t                kind;
    coord_t                    px;
    coord_t                    py;
    logic [REG_INDEX_W-1:0]    index;
    logic [COORD_W-1:0]        data;
  } request_t;

  typedef struct {
    coord_t px;
    coord_t py;
    logic   hit;
  } verdict_t;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   start    = 1'b0;
  logic                   busy;
  coord_t                 point_x  = '0;
  coord_t                 point_y  = '0;
  logic                   done;
  logic                   on_arc;
  logic                   wr_en    = 1'b0;
  logic [REG_INDEX_W-1:0] wr_index = '0;
  logic [COORD_W-1:0]     wr_data  = '0;

  request_t requests[$];
  verdict_t verdicts_due[$];

  // Our own copy of the arc registers, updated when a write is issued.
  // Writes are only issued while nothing is in flight, so every query that
  // is accepted afterwards sees the new values in the block as well.
  coord_t arc_cx = '0;
  coord_t arc_cy = '0;
  coord_t arc_sx = '0;
  coord_t arc_sy = '0;
  coord_t arc_ex = '0;
  coord_t arc_ey = '0;
  logic   arc_cw = 1'b0;

  // Arc currently being generated, used to aim queries near its limits.
  int gen_cx, gen_cy, gen_sx, gen_sy, gen_ex, gen_ey;

  int queries_planned = 0;
  int queries_sent    = 0;
  int results_seen    = 0;
  int hits            = 0;
  int arc_count       = 0;
  int mismatches      = 0;

  arc_point_membership_top #(
    .COORD_WIDTH   (COORD_W),
    .ANGLE_BITS    (ANGLE_W),
    .CORDIC_STAGES (STAGES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .point_x  (point_x),
    .point_y  (point_y),
    .done     (done),
    .on_arc   (on_arc),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Angle of (dx, dy) as a binary angle by CORDIC vectoring. The vector is
  // scaled by 2^26 first, folded into the right half plane when x is
  // negative, and then driven toward the x axis one stage at a time while
  // the rounded table angles are summed. Shifts are floor shifts.
  function automatic longint binary_angle(input longint dx, input longint dy);
    longint x, y, z, xs, ys, step;
    if (dx == 0 && dy == 0) begin
      return 0;
    end
    x = dx * (longint'(1) << GUARD_BITS);
    y = dy * (longint'(1) << GUARD_BITS);
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = longint'(1) << (ANGLE_W - 1);
    end
    for (int i = 0; i < STAGES; i++) begin
      xs   = x >>> i;
      ys   = y >>> i;
      step = (longint'(ATAN_TURN[i]) + (longint'(1) << (31 - ANGLE_W))) >>> (32 - ANGLE_W);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + step;
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - step;
      end
    end
    return z & (TURN - 1);
  endfunction

  // Membership verdict for one query against the current arc registers.
  // Coinciding limit points mean a full circle. Otherwise the query angle
  // is unwrapped past the start angle and compared with the end angle, with
  // the direction deciding which side of the start counts as inside.
  function automatic logic arc_hit(input coord_t px, input coord_t py);
    longint t_start, t_end, t_pt;
    if (arc_sx == arc_ex && arc_sy == arc_ey) begin
      return 1'b1;
    end
    t_start = binary_angle(longint'(arc_sx) - longint'(arc_cx),
                           longint'(arc_sy) - longint'(arc_cy));
    t_end   = binary_angle(longint'(arc_ex) - longint'(arc_cx),
                           longint'(arc_ey) - longint'(arc_cy));
    t_pt    = binary_angle(longint'(px) - longint'(arc_cx),
                           longint'(py) - longint'(arc_cy));
    if (arc_cw) begin
      if (t_pt <= t_start) begin
        t_pt = t_pt + TURN;
      end
      if (t_end < t_start) begin
        t_end = t_end + TURN;
      end
      return t_pt >= t_end;
    end else begin
      if (t_end <= t_start) begin
        t_end = t_end + TURN;
      end
      if (t_pt < t_start) begin
        t_pt = t_pt + TURN;
      end
      return t_pt <= t_end;
    end
  endfunction

  // Mirrors a register write into our copy. Bits above a register's width
  // drop out, and an index past the list changes nothing.
  function automatic void load_register(input logic [REG_INDEX_W-1:0] index,
                                        input logic [COORD_W-1:0] data);
    case (index)
      REG_CENTER_X:  arc_cx = data;
      REG_CENTER_Y:  arc_cy = data;
      REG_START_X:   arc_sx = data;
      REG_START_Y:   arc_sy = data;
      REG_END_X:     arc_ex = data;
      REG_END_Y:     arc_ey = data;
      REG_CLOCKWISE: arc_cw = data[0];
      default:       ;
    endcase
  endfunction

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic add_point(input int x, input int y);
    requests.push_back('{STEP_POINT, coord_t'(x), coord_t'(y), '0, '0});
    queries_planned++;
  endtask

  task automatic add_write(input logic [REG_INDEX_W-1:0] index, input int data);
    requests.push_back('{STEP_WRITE, '0, '0, index, data[COORD_W-1:0]});
  endtask

  task automatic add_wait();
    requests.push_back('{STEP_WAIT, '0, '0, '0, '0});
  endtask

  // Writes all seven registers for a new arc. The direction register also
  // gets random upper bits, which the block has to ignore, and now and then
  // a write to the unused index is slipped in.
  task automatic add_arc(input int cx, input int cy, input int sx, input int sy,
                         input int ex, input int ey, input logic cw);
    gen_cx = cx;
    gen_cy = cy;
    gen_sx = sx;
    gen_sy = sy;
    gen_ex = ex;
    gen_ey = ey;
    add_write(REG_CENTER_X, cx);
    add_write(REG_CENTER_Y, cy);
    add_write(REG_START_X, sx);
    add_write(REG_START_Y, sy);
    add_write(REG_END_X, ex);
    add_write(REG_END_Y, ey);
    add_write(REG_CLOCKWISE, ($urandom & 32'hFFFE) | cw);
    if ($urandom_range(3) == 0) begin
      add_write(REG_SPARE, $urandom);
    end
    arc_count++;
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(2))
      0:       return -32768;
      1:       return 32767;
      default: return 0;
    endcase
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Driver. A query waits at the head of the queue until the sender decides
  // not to idle this cycle; it then stays on the ports until it is accepted.
  // Register writes and pauses wait until no verdict is outstanding and no
  // strobe is in progress, so the block is idle whenever its arc changes.
  // Idling is switched off for a long stretch in the middle of the run.
  always @(posedge clk) begin : driver
    request_t head;
    logic     accepted;
    logic     quiet;
    logic     gaps_on;
    logic     nxt_start;
    logic     nxt_wr;
    accepted  = start && !busy;
    nxt_start = 1'b0;
    nxt_wr    = 1'b0;
    if (!rst) begin
      if (accepted) begin
        verdicts_due.push_back('{point_x, point_y, arc_hit(point_x, point_y)});
        void'(requests.pop_front());
        queries_sent++;
      end
      quiet   = (verdicts_due.size() == 0) && !done;
      gaps_on = (queries_sent < 600) || (queries_sent >= 1000);
      if (start && !accepted) begin
        nxt_start = 1'b1;
      end else if (requests.size() != 0) begin
        head = requests[0];
        case (head.kind)
          STEP_POINT: begin
            if (!(gaps_on && $urandom_range(99) < 22)) begin
              nxt_start = 1'b1;
              point_x  <= head.px;
              point_y  <= head.py;
            end
          end
          STEP_WRITE: begin
            if (quiet) begin
              nxt_wr    = 1'b1;
              wr_index <= head.index;
              wr_data  <= head.data;
              load_register(head.index, head.data);
              void'(requests.pop_front());
            end
          end
          default: begin
            if (quiet) begin
              void'(requests.pop_front());
            end
          end
        endcase
      end
    end
    start <= nxt_start;
    wr_en <= nxt_wr;
  end

  // Monitor. Every done strobe is a verdict the receiver must take in that
  // very cycle; it is checked against the oldest outstanding prediction.
  always @(posedge clk) begin : monitor
    verdict_t due;
    if (!rst && done) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("on_arc strobe with no query outstanding");
      end else begin
        due = verdicts_due.pop_front();
        results_seen++;
        if (on_arc === 1'b1) begin
          hits++;
        end
        if (on_arc !== due.hit) begin
          report_mismatch($sformatf("point (%0d, %0d): on_arc %b, predicted %b",
                                    due.px, due.py, on_arc, due.hit));
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int ring_x [0:6];
    int ring_y [0:6];
    int n;
    int r;
    int k;
    int bx;
    int by;
    int cx;
    int cy;
    int dx;
    int dy;

    // Directed part. With the registers at reset the limit points coincide,
    // so even the field extremes must come back as on the arc.
    add_point(-32768, -32768);
    add_point(32767, 32767);
    add_point(0, 0);
    add_point(-32768, 32767);
    add_write(REG_SPARE, 16'hFFFF);

    // A quarter arc in both directions: both limit points, the middle, the
    // far side, the center itself and a point just below the start.
    ring_x = '{1000, 0, 707, -1000, 0, 0, 1000};
    ring_y = '{0, 1000, 707, 0, -1000, 0, -1};
    for (int cw = 0; cw < 2; cw++) begin
      add_arc(0, 0, 1000, 0, 0, 1000, cw[0]);
      for (int i = 0; i < 7; i++) begin
        add_point(ring_x[i], ring_y[i]);
      end
    end

    // Limit points at the same angle but different places: a full circle.
    add_arc(0, 0, 100, 100, 200, 200, $urandom_range(1));
    add_point(-5, 3);
    add_point(100, -100);

    // Random part, one arc after another.
    while (queries_planned < 1770) begin
      case ($urandom_range(5))
        0: begin
          add_arc($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(1));
        end
        1, 2: begin
          cx = jitter(8000);
          cy = jitter(8000);
          r  = $urandom_range(1, 12000);
          add_arc(cx, cy, cx + jitter(r), cy + jitter(r), cx + jitter(r), cy + jitter(r),
                  $urandom_range(1));
        end
        3: begin
          // Coinciding limit points anywhere.
          bx = $urandom;
          by = $urandom;
          add_arc($urandom, $urandom, bx, by, bx, by, $urandom_range(1));
        end
        4: begin
          // Distinct limit points on one ray from the center.
          cx = jitter(10000);
          cy = jitter(10000);
          do begin
            dx = jitter(5000);
            dy = jitter(5000);
          end while (dx == 0 && dy == 0);
          add_arc(cx, cy, cx + dx, cy + dy, cx + 2 * dx, cy + 2 * dy, $urandom_range(1));
        end
        default: begin
          add_arc(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                  pick_extreme(), pick_extreme(), $urandom_range(1));
        end
      endcase

      n = $urandom_range(40, 100);
      for (int j = 0; j < n; j++) begin
        r = $urandom_range(99);
        if (r < 25) begin
          add_point($urandom, $urandom);
        end else if (r < 65) begin
          // Along one of the limit rays, a little off it, to probe the
          // boundaries of the range.
          if ($urandom_range(1) == 0) begin
            bx = gen_sx - gen_cx;
            by = gen_sy - gen_cy;
          end else begin
            bx = gen_ex - gen_cx;
            by = gen_ey - gen_cy;
          end
          k = $urandom_range(1, 3);
          add_point(gen_cx + k * bx + jitter(2), gen_cy + k * by + jitter(2));
        end else if (r < 85) begin
          k = $urandom_range(1, 3000);
          add_point(gen_cx + jitter(k), gen_cy + jitter(k));
        end else if (r < 92) begin
          add_point(gen_cx, gen_cy);
        end else begin
          add_point(pick_extreme(), pick_extreme());
        end
        if (j == n / 2 && $urandom_range(2) == 0) begin
          add_wait();
        end
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (requests.size() != 0 || start || verdicts_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 8) @(posedge clk);

    $display("Checked %0d membership queries over %0d arc settings; %0d were on the arc.",
             results_seen, arc_count, hits);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hang; a correct run needs a small fraction of this.
  initial begin : watchdog
    #2000000;
    $display("Timeout with %0d verdicts outstanding.", verdicts_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
